@@ hdl/fdcd_pkg.sv @@
package fdcd_pkg;

  localparam int DEFAULT_MAX_PIXELS = 65536;

  localparam int SAMPLE_W    = 8;
  localparam int PIXEL_W     = 3 * SAMPLE_W;
  localparam int METRIC_W    = 26;
  localparam int TERM_W      = 10;
  localparam int THRESH_W    = 26;
  localparam int FPIX_W      = 17;
  localparam int INDEX_W     = 16;
  localparam int FRAC_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 26;

  // queue between front and back
  localparam int QUEUE_DEPTH = 8;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COUNT_MODE      = 3'd0,
    REG_COLOUR_MODE     = 3'd1,
    REG_PIXEL_THRESHOLD = 3'd2,
    REG_FRAME_THRESHOLD = 3'd3,
    REG_FRAME_PIXELS    = 3'd4
  } fdcd_reg_t;

  typedef struct packed {
    logic                count_mode;
    logic                colour_mode;
    logic [SAMPLE_W-1:0] pixel_threshold;
    logic [THRESH_W-1:0] frame_threshold;
    logic [FPIX_W-1:0]   frame_pixels;
  } fdcd_cfg_t;

  typedef struct packed {
    logic           valid;
    logic [QCW-1:0] count;
  } fdcd_queue_status_t;

endpackage

@@ hdl/fdcd_front.sv @@
module fdcd_front import fdcd_pkg::*; #(
  parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS,
  localparam int AW  = $clog2(MAX_PIXELS),
  localparam int NPW = $clog2(MAX_PIXELS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  fdcd_cfg_t           cfg,
  input  logic [NPW-1:0]      npix,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] gray_or_red,
  input  logic [SAMPLE_W-1:0] green,
  input  logic [SAMPLE_W-1:0] blue,
  input  fdcd_queue_status_t  qstat,
  output logic                push,
  output logic [METRIC_W-1:0] push_metric
);

  localparam int ZW = QCW + 1;

  logic [PIXEL_W-1:0] store [MAX_PIXELS];

  logic [AW-1:0]       pos;
  logic                first;
  logic                accept;
  logic                last_now;

  logic                s1_valid;
  logic                s1_first;
  logic                s1_last;
  logic [PIXEL_W-1:0]  s1_pixel;
  logic [PIXEL_W-1:0]  s1_prev;

  logic                s2_valid;
  logic                s2_first;
  logic                s2_last;
  logic [TERM_W-1:0]   s2_term;
  logic [TERM_W-1:0]   term;

  logic [METRIC_W-1:0] acc;
  logic [METRIC_W:0]   acc_sum;
  logic [METRIC_W-1:0] acc_new;

  function automatic logic [TERM_W-1:0] chan_term(
    input logic [SAMPLE_W-1:0] a,
    input logic [SAMPLE_W-1:0] b,
    input logic                cnt,
    input logic [SAMPLE_W-1:0] thr
  );
    logic [SAMPLE_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    if (cnt) begin
      return TERM_W'(d > thr);
    end
    return TERM_W'(d);
  endfunction

  // room for every item still in flight plus this one
  assign in_ready = (ZW'(qstat.count) + ZW'(s1_valid) + ZW'(s2_valid)) < ZW'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign last_now = (NPW'(pos) + NPW'(1)) >= npix;

  // read-first store: old pixel comes out, new one goes in
  always_ff @(posedge clk) begin
    if (accept) begin
      store[pos] <= {blue, green, gray_or_red};
      s1_prev    <= store[pos];
      s1_pixel   <= {blue, green, gray_or_red};
      s1_first   <= first;
      s1_last    <= last_now;
    end
  end

  always_comb begin
    term = chan_term(s1_pixel[SAMPLE_W-1:0], s1_prev[SAMPLE_W-1:0],
                     cfg.count_mode, cfg.pixel_threshold);
    if (cfg.colour_mode) begin
      term = term
           + chan_term(s1_pixel[2*SAMPLE_W-1:SAMPLE_W], s1_prev[2*SAMPLE_W-1:SAMPLE_W],
                       cfg.count_mode, cfg.pixel_threshold)
           + chan_term(s1_pixel[PIXEL_W-1:2*SAMPLE_W], s1_prev[PIXEL_W-1:2*SAMPLE_W],
                       cfg.count_mode, cfg.pixel_threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_term  <= term;
      s2_first <= s1_first;
      s2_last  <= s1_last;
    end
  end

  // saturating accumulate
  assign acc_sum     = {1'b0, acc} + (METRIC_W+1)'(s2_term);
  assign acc_new     = s2_first ? acc : (acc_sum[METRIC_W] ? '1 : acc_sum[METRIC_W-1:0]);
  assign push        = s2_valid && s2_last && !s2_first;
  assign push_metric = acc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      first    <= 1'b1;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      acc      <= '0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (accept) begin
        if (last_now) begin
          pos   <= '0;
          first <= 1'b0;
        end else begin
          pos <= pos + AW'(1);
        end
      end
      if (s2_valid) begin
        acc <= s2_last ? '0 : acc_new;
      end
    end
  end

endmodule

@@ hdl/fdcd_queue.sv @@
module fdcd_queue import fdcd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [METRIC_W-1:0] push_data,
  input  logic                pop,
  output fdcd_queue_status_t  qstat,
  output logic [METRIC_W-1:0] q_data
);

  logic [METRIC_W-1:0] slots [QUEUE_DEPTH];
  logic [QAW-1:0]      wr_ptr;
  logic [QAW-1:0]      rd_ptr;
  logic [QCW-1:0]      count;

  assign qstat.valid = (count != '0);
  assign qstat.count = count;
  assign q_data      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

@@ hdl/fdcd_back.sv @@
module fdcd_back import fdcd_pkg::*; #(
  parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS,
  localparam int NPW = $clog2(MAX_PIXELS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  fdcd_cfg_t           cfg,
  input  logic [NPW-1:0]      npix,
  input  fdcd_queue_status_t  qstat,
  input  logic [METRIC_W-1:0] q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [INDEX_W-1:0]  frame_index,
  output logic                is_cut,
  output logic [METRIC_W-1:0] metric_total
);

  localparam int PW   = THRESH_W + NPW;
  localparam int LW   = METRIC_W + FRAC_W;
  localparam int CMPW = (PW > LW) ? PW : LW;

  logic                b1_valid;
  logic                b1_advance;
  logic [METRIC_W-1:0] b1_metric;
  logic [INDEX_W-1:0]  b1_index;
  logic [PW-1:0]       b1_product;
  logic [INDEX_W-1:0]  pair_count;
  logic [CMPW-1:0]     lhs;
  logic [CMPW-1:0]     rhs;

  assign b1_advance = b1_valid && (!out_valid || out_ready);
  assign pop        = qstat.valid && (!b1_valid || b1_advance);

  assign lhs = CMPW'({b1_metric, FRAC_W'(0)});
  assign rhs = CMPW'(b1_product);

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_metric  <= q_data;
      b1_index   <= pair_count;
      b1_product <= PW'(cfg.frame_threshold) * PW'(npix);
    end
    if (b1_advance) begin
      frame_index  <= b1_index;
      metric_total <= b1_metric;
      is_cut       <= lhs > rhs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      pair_count <= '0;
    end else begin
      if (pop) begin
        b1_valid   <= 1'b1;
        pair_count <= pair_count + INDEX_W'(1);
      end else if (b1_advance) begin
        b1_valid <= 1'b0;
      end
      if (b1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/frame_difference_cut_detector_core.sv @@
// Frame difference cut detector.
// Pixels enter on the in channel (in_valid/in_ready, gray_or_red, green, blue)
// in raster order, one transfer per pixel; up to one pixel per clock is taken.
// Each pixel is compared with the same position of the previous frame, held
// in an on-chip store of MAX_PIXELS entries. The first frame after reset is
// only stored. At the last pixel of every later frame one result transfer
// leaves on the out channel: frame_index, is_cut, metric_total.
// A result passes front stages s1 and s2, the result queue, back stage b1
// and the output register. Throughput is set by the store's single read
// and write port: one pixel per cycle sustained while in_ready is high.
// The front (store, difference and accumulate) and the back (threshold
// multiply, compare, output register) are joined by an 8-entry result queue.
// When the receiver stalls, results collect in the queue; in_ready drops once
// the queue entries plus the pixels in front stages s1 and s2 reach its depth.
// Config: cfg_valid/cfg_index/cfg_data, always ready; write only while idle.
// Reset (rst, synchronous): registers to defaults, position 0, next frame
// treated as the first. The pixel store is not cleared.
module frame_difference_cut_detector_core import fdcd_pkg::*; #(
  parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_W-1:0]    gray_or_red,
  input  logic [SAMPLE_W-1:0]    green,
  input  logic [SAMPLE_W-1:0]    blue,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [INDEX_W-1:0]     frame_index,
  output logic                   is_cut,
  output logic [METRIC_W-1:0]    metric_total
);

  localparam int NPW = $clog2(MAX_PIXELS + 1);
  // common width for clamping the frame size register against MAX_PIXELS
  localparam int CW  = (NPW > FPIX_W) ? NPW : FPIX_W;

  fdcd_cfg_t           cfg;
  logic [NPW-1:0]      npix;
  logic [CW-1:0]       fp_wide;
  fdcd_queue_status_t  qstat;
  logic [METRIC_W-1:0] q_data;
  logic                push;
  logic [METRIC_W-1:0] push_metric;
  logic                pop;

  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_mode      <= 1'b0;
      cfg.colour_mode     <= 1'b0;
      cfg.pixel_threshold <= '0;
      cfg.frame_threshold <= '0;
      cfg.frame_pixels    <= FPIX_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COUNT_MODE:      cfg.count_mode      <= cfg_data[0];
        REG_COLOUR_MODE:     cfg.colour_mode     <= cfg_data[0];
        REG_PIXEL_THRESHOLD: cfg.pixel_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_FRAME_THRESHOLD: cfg.frame_threshold <= cfg_data[THRESH_W-1:0];
        REG_FRAME_PIXELS:    cfg.frame_pixels    <= cfg_data[FPIX_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero reads as one, large values clip to MAX_PIXELS
  assign fp_wide = CW'(cfg.frame_pixels);
  always_comb begin
    if (fp_wide == '0) begin
      npix = NPW'(1);
    end else if (fp_wide > CW'(MAX_PIXELS)) begin
      npix = NPW'(MAX_PIXELS);
    end else begin
      npix = fp_wide[NPW-1:0];
    end
  end

  fdcd_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .npix        (npix),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .gray_or_red (gray_or_red),
    .green       (green),
    .blue        (blue),
    .qstat       (qstat),
    .push        (push),
    .push_metric (push_metric)
  );

  fdcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_metric),
    .pop       (pop),
    .qstat     (qstat),
    .q_data    (q_data)
  );

  fdcd_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .npix         (npix),
    .qstat        (qstat),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_index  (frame_index),
    .is_cut       (is_cut),
    .metric_total (metric_total)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import fdcd_pkg::*; ();

  // Pixel store size of the block (default parameter).
  localparam int MAX_PIX = DEFAULT_MAX_PIXELS;
  localparam int unsigned METRIC_MAX = (1 << METRIC_W) - 1;
  localparam int unsigned FT_MAX = 50200575;
  // Margin after the last pixel; it covers anything still in flight
  // before a register write or the end.
  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_PIXELS = 1150;
  // Size of the first frame; no later frame runs past it, so every position
  // read back has been written.
  localparam int FIRST_FRAME_PIXELS = 48;

  typedef struct packed {
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
  } pixel_t;

  typedef struct {
    logic [INDEX_W-1:0]  frame_index;
    logic                is_cut;
    logic [METRIC_W-1:0] metric_total;
  } frame_verdict_t;

  typedef struct {
    fdcd_reg_t             index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // DUT signals; the inputs are at known values from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   gray_or_red = '0;
  logic [SAMPLE_W-1:0]   green = '0;
  logic [SAMPLE_W-1:0]   blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [INDEX_W-1:0]    frame_index;
  logic                  is_cut;
  logic [METRIC_W-1:0]   metric_total;

  // Stimulus queues filled by the sequencer, drained by the drivers.
  pixel_t     pixel_q[$];
  reg_write_t reg_write_q[$];

  // Pacing knobs, percent of cycles spent idle / stalled.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Long receiver hold-off: total cycles requested vs. cycles already held.
  int hold_request = 0;
  int hold_served = 0;

  // Generator view: what each store position will hold once all queued
  // pixels are in, and where the next queued pixel lands.
  pixel_t      scene[MAX_PIX];
  int unsigned gen_pos = 0;

  // Predictor state, updated on every accepted transfer.
  fdcd_cfg_t          shadow_cfg;
  pixel_t             prev_frame[MAX_PIX];
  int unsigned        pix_pos;
  int unsigned        metric_acc;
  bit                 first_frame;
  logic [INDEX_W-1:0] pair_count;
  frame_verdict_t     verdict_q[$];

  int error_count = 0;
  int cycle_count = 0;

  pixel_t         next_px;
  reg_write_t     next_write;
  frame_verdict_t want;

  frame_difference_cut_detector_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .gray_or_red  (gray_or_red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_index  (frame_index),
    .is_cut       (is_cut),
    .metric_total (metric_total)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // Frame size as the block uses it: 0 acts as 1, oversize clamps to store.
  function automatic int unsigned eff_pixels();
    int unsigned n;
    n = shadow_cfg.frame_pixels;
    if (n == 0) n = 1;
    if (n > MAX_PIX) n = MAX_PIX;
    return n;
  endfunction

  // Per-channel contribution: raw |diff| in sum mode, 0/1 in count mode.
  function automatic int unsigned channel_term(logic [7:0] a, logic [7:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    if (shadow_cfg.count_mode) return (d > shadow_cfg.pixel_threshold) ? 1 : 0;
    return d;
  endfunction

  function automatic void write_shadow_reg(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
    case (fdcd_reg_t'(idx))
      REG_COUNT_MODE:      shadow_cfg.count_mode = data[0];
      REG_COLOUR_MODE:     shadow_cfg.colour_mode = data[0];
      REG_PIXEL_THRESHOLD: shadow_cfg.pixel_threshold = data[SAMPLE_W-1:0];
      REG_FRAME_THRESHOLD: shadow_cfg.frame_threshold = data[THRESH_W-1:0];
      REG_FRAME_PIXELS:    shadow_cfg.frame_pixels = data[FPIX_W-1:0];
      default: ;
    endcase
  endfunction

  // One accepted pixel: compare against the stored frame, accumulate, and
  // at the frame's last pixel queue the cut verdict for that frame pair.
  function automatic void accumulate_pixel(pixel_t px);
    int unsigned    npix;
    int unsigned    pos;
    int unsigned    term;
    pixel_t         prev;
    longint unsigned lhs;
    longint unsigned rhs;
    frame_verdict_t res;
    npix = eff_pixels();
    pos = pix_pos;
    if (!first_frame) begin
      prev = prev_frame[pos];
      term = channel_term(px.red, prev.red);
      if (shadow_cfg.colour_mode)
        term += channel_term(px.green, prev.green) + channel_term(px.blue, prev.blue);
      metric_acc = (metric_acc + term > METRIC_MAX) ? METRIC_MAX : metric_acc + term;
    end
    prev_frame[pos] = px;
    if (pos + 1 >= npix) begin
      if (!first_frame) begin
        // mean > threshold, with the division moved to the other side
        lhs = 64'(metric_acc) << FRAC_W;
        rhs = 64'(shadow_cfg.frame_threshold) * 64'(npix);
        res.frame_index = pair_count;
        res.is_cut = (lhs > rhs);
        res.metric_total = metric_acc[METRIC_W-1:0];
        verdict_q = {verdict_q, res};
        pair_count++;
      end
      first_frame = 1'b0;
      metric_acc = 0;
      pix_pos = 0;
    end else begin
      pix_pos = pos + 1;
    end
  endfunction

  function automatic void log_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // ------------------------------------------------------------------
  // Drivers and monitor
  // ------------------------------------------------------------------

  // Pixel driver: new transfer only when the slot is free; valid holds
  // with a stable payload until the transfer happens.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_px = pixel_q.pop_front();
        in_valid <= 1'b1;
        gray_or_red <= next_px.red;
        green <= next_px.green;
        blue <= next_px.blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Register write driver, back to back.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (reg_write_q.size() != 0) begin
        next_write = reg_write_q.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= next_write.index;
        cfg_data <= next_write.data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // Receiver: a requested hold-off wins, else random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_served < hold_request) begin
      out_ready <= 1'b0;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: feeds every transfer into the predictor and checks results
  // in order against the oldest pending verdict.
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg.count_mode = 1'b0;
      shadow_cfg.colour_mode = 1'b0;
      shadow_cfg.pixel_threshold = '0;
      shadow_cfg.frame_threshold = '0;
      shadow_cfg.frame_pixels = FPIX_W'(MAX_PIX);
      pix_pos = 0;
      metric_acc = 0;
      first_frame = 1'b1;
      pair_count = '0;
    end else begin
      if (cfg_valid && cfg_ready) write_shadow_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) accumulate_pixel({blue, green, gray_or_red});
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          log_failure($sformatf("unexpected result: index %0d cut %0b metric %0d",
                                frame_index, is_cut, metric_total));
        end else begin
          want = verdict_q.pop_front();
          if (frame_index !== want.frame_index || is_cut !== want.is_cut ||
              metric_total !== want.metric_total)
            log_failure($sformatf(
              "result mismatch: exp index %0d cut %0b metric %0d, got %0d %0b %0d",
              want.frame_index, want.is_cut, want.metric_total,
              frame_index, is_cut, metric_total));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sequencer helpers
  // ------------------------------------------------------------------

  // Wait until every queued transfer is done and every verdict has come
  // back, then let the pipeline settle. Returns off the clock edge.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_q.size() != 0 || reg_write_q.size() != 0 || in_valid ||
               cfg_valid || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
  endtask

  function automatic void write_reg(fdcd_reg_t idx, int unsigned value);
    reg_write_t w;
    w.index = idx;
    w.data = CFG_DATA_W'(value);
    reg_write_q = {reg_write_q, w};
  endfunction

  // Queue one pixel and track where the block will be once it is taken.
  // Frame size is stable here: registers change only while idle.
  function automatic void push_pixel(pixel_t px);
    pixel_q = {pixel_q, px};
    scene[gen_pos] = px;
    gen_pos = (gen_pos + 1 >= eff_pixels()) ? 0 : gen_pos + 1;
  endfunction

  function automatic pixel_t rand_pixel();
    return pixel_t'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] base, int noise);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * noise)) - noise;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Queue whole frames: mostly the previous scene with a little noise,
  // some fully redrawn (hard cuts). Optionally stop mid-frame.
  function automatic int queue_scene(int frames, int cut_pct, bit allow_partial);
    int     n;
    int     noise;
    int     total;
    bit     cut;
    pixel_t px;
    total = 0;
    for (int f = 0; f < frames; f++) begin
      cut = ($urandom_range(99) < cut_pct);
      noise = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 48);
      n = (gen_pos + 1 >= eff_pixels()) ? 1 : eff_pixels() - gen_pos;
      if (allow_partial && f == frames - 1 && $urandom_range(3) == 0)
        n = $urandom_range(1, n);
      for (int k = 0; k < n; k++) begin
        if (cut) begin
          px = rand_pixel();
        end else begin
          px = scene[gen_pos];
          px.red = jitter(px.red, noise);
          px.green = jitter(px.green, noise);
          px.blue = jitter(px.blue, noise);
        end
        push_pixel(px);
        total++;
      end
    end
    return total;
  endfunction

  // Random register set; frame threshold scaled so both verdicts occur.
  function automatic void random_setup(int unsigned fpix);
    int unsigned cm;
    int unsigned col;
    int unsigned scale;
    int unsigned ft;
    int unsigned pt;
    cm = $urandom_range(1);
    col = $urandom_range(1);
    scale = cm ? (col ? 3 : 1) : (col ? 765 : 255);
    case ($urandom_range(9))
      0: ft = 0;
      1: ft = FT_MAX;
      default: ft = $urandom_range(0, (scale << FRAC_W) / 2);
    endcase
    if ($urandom_range(7) == 0) pt = $urandom_range(1) ? 255 : 0;
    else pt = $urandom_range(0, 48);
    write_reg(REG_COUNT_MODE, cm);
    write_reg(REG_COLOUR_MODE, col);
    write_reg(REG_PIXEL_THRESHOLD, pt);
    write_reg(REG_FRAME_THRESHOLD, ft);
    write_reg(REG_FRAME_PIXELS, fpix);
  endfunction

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    int random_pixels;
    int unsigned fpix;
    random_pixels = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    send_idle_pct = 23;
    recv_stall_pct = 78;

    // First frame is as long as any later frame runs, so no later
    // frame can read a position that was never written.
    // It is only stored: no verdict.
    write_reg(REG_FRAME_PIXELS, FIRST_FRAME_PIXELS);
    wait_idle();
    for (int k = 0; k < FIRST_FRAME_PIXELS; k++) push_pixel(rand_pixel());
    wait_idle();

    // Directed: colour sum mode, 4-pixel frames. Full white, then full
    // black (max difference, cut at zero threshold), then black again
    // (zero metric, strict compare says no cut).
    write_reg(REG_COUNT_MODE, 0);
    write_reg(REG_COLOUR_MODE, 1);
    write_reg(REG_PIXEL_THRESHOLD, 0);
    write_reg(REG_FRAME_THRESHOLD, 0);
    write_reg(REG_FRAME_PIXELS, 4);
    wait_idle();
    repeat (4) push_pixel(24'hFFFFFF);
    repeat (8) push_pixel(24'h000000);
    wait_idle();

    // Directed: gray count mode, frame size 0 acts as one pixel per frame,
    // pixel threshold 254, frame threshold FT_MAX; green/blue must be ignored.
    write_reg(REG_COUNT_MODE, 1);
    write_reg(REG_COLOUR_MODE, 0);
    write_reg(REG_PIXEL_THRESHOLD, 254);
    write_reg(REG_FRAME_THRESHOLD, FT_MAX);
    write_reg(REG_FRAME_PIXELS, 0);
    wait_idle();
    push_pixel(24'h0000FF);
    push_pixel(24'hFFFF00);
    push_pixel(24'h00FFFF);
    wait_idle();

    // Directed: start an 8-pixel frame, then shrink the frame and switch
    // to count mode mid-frame; the next pixel closes the frame.
    write_reg(REG_COUNT_MODE, 0);
    write_reg(REG_PIXEL_THRESHOLD, 0);
    write_reg(REG_FRAME_THRESHOLD, 1 << FRAC_W);
    write_reg(REG_FRAME_PIXELS, 8);
    wait_idle();
    repeat (5) push_pixel(rand_pixel());
    wait_idle();
    write_reg(REG_COUNT_MODE, 1);
    write_reg(REG_PIXEL_THRESHOLD, 10);
    write_reg(REG_FRAME_PIXELS, 3);
    wait_idle();
    repeat (4) push_pixel(rand_pixel());
    wait_idle();

    // Backpressure: one-pixel frames give a verdict per pixel while the
    // receiver holds off for a long stretch; the result queue fills and
    // in_ready must drop. wait_idle afterwards is the sender pause.
    random_setup(1);
    wait_idle();
    hold_request = hold_request + 300;
    random_pixels += queue_scene(40, 25, 1'b0);
    wait_idle();

    // Random phases. Mostly small frames so verdicts come often.
    while (random_pixels < RANDOM_PIXELS) begin
      if (random_pixels >= (2 * RANDOM_PIXELS) / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (random_pixels >= RANDOM_PIXELS / 3) begin
        send_idle_pct = 78;
        recv_stall_pct = 23;
      end
      if ($urandom_range(3) == 0) fpix = $urandom_range(0, 4);
      else fpix = $urandom_range(5, FIRST_FRAME_PIXELS);
      random_setup(fpix);
      wait_idle();
      random_pixels += queue_scene($urandom_range(1, 4), 25, 1'b1);
      wait_idle();
    end

    // Oversized frame register clamps to the full store: the frame runs on
    // past every small size. Shrinking it then closes the frame at the
    // next pixel.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_COUNT_MODE, 0);
    write_reg(REG_COLOUR_MODE, 1);
    write_reg(REG_FRAME_THRESHOLD, $urandom_range(0, FT_MAX));
    write_reg(REG_FRAME_PIXELS, (1 << FPIX_W) - 1);
    wait_idle();
    while (gen_pos < FIRST_FRAME_PIXELS - 1) push_pixel(rand_pixel());
    wait_idle();
    write_reg(REG_FRAME_PIXELS, 2);
    wait_idle();
    push_pixel(rand_pixel());
    wait_idle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ frame_difference_cut_detector_core.f @@
hdl/fdcd_pkg.sv
hdl/fdcd_front.sv
hdl/fdcd_queue.sv
hdl/fdcd_back.sv
hdl/frame_difference_cut_detector_core.sv
tb/sv/tb_top.sv
